>>> sv/sha256_stream_hasher_core_defines.svh
// assertion helpers for the stream hasher
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/shs_pkg.sv
package shs_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [63:0] digest_bits_255_192;
		logic [63:0] digest_bits_191_128;
		logic [63:0] digest_bits_127_64;
		logic [63:0] digest_bits_63_0;
	} out_t;

	localparam word_t HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0]  PAD_BYTE    = 8'h80;
	localparam logic [5:0]  LEN_POS     = 6'd56;
	localparam logic [5:0]  LAST_POS    = 6'd63;
	localparam logic [3:0]  LEN_HI_IDX  = 4'd14;
	localparam logic [3:0]  LEN_LO_IDX  = 4'd15;
	localparam logic [60:0] COUNT_MAX   = '1;

	// compression sequencer: word reads lead the schedule, which in turn leads the rounds
	localparam logic [6:0] SCHED_OFS   = 7'd2;
	localparam logic [6:0] SCHED_FIRST = 7'd18;
	localparam logic [6:0] SCHED_LAST  = 7'd65;
	localparam logic [6:0] ROUND_FIRST = 7'd3;
	localparam logic [6:0] ROUND_LAST  = 7'd66;
	localparam logic [6:0] CNT_LAST    = 7'd67;
	localparam logic [3:0] TAP7_OFS    = 4'd8;

	function automatic word_t ror(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

>>> sv/sha256_stream_hasher_core.sv
// SHA-256 over a byte stream.
// in channel (in_valid / in_stall / in_data): each item carries an optional byte and
// an end-of-message flag. out channel (out_valid / out_stall / out_data): one digest
// item per message, digest byte 0 in the top bits of digest_bits_255_192.
// An item is taken while the core is idle; in_stall is high in every other state. The
// item that completes a 64-byte block holds the input off for the compression, a
// one-round-per-cycle loop reading the 16-word schedule memory on two ports.
// End of message: padding writes the rest of the block one word per cycle, then
// compresses; when fewer than 9 bytes are left in the block a second pad block,
// padded and compressed the same way, follows. The done state then moves the
// digest into the output register once the slot is free, which frees the core
// for the next message.
// A digest that waits on out_stall holds in the output register; the next message
// can be hashed meanwhile and only its own digest hand-over waits for the slot.
// Reset: asynchronous, active low; the core comes up idle with the initial hash
// values loaded, no bytes counted and no digest pending. No clearing pass is needed.
`include "sha256_stream_hasher_core_defines.svh"

module sha256_stream_hasher_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  shs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output shs_pkg::out_t out_data
);
	import shs_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_DONE} state_t;

	state_t      state_q;
	logic [6:0]  cnt_q;
	logic [3:0]  pw_q;
	logic        first_q;
	logic        final_q;
	logic        pad_q;
	logic [5:0]  bcnt_q;
	logic [60:0] count_q;
	logic        out_valid_q;
	word_t       acc_q;
	word_t       h_q [8];
	word_t       v_q [8];
	out_t        out_q;

	// schedule / block memory
	word_t       mem [16];
	word_t       rdata_a_q;
	word_t       rdata_b_q;
	logic        we;
	logic [3:0]  waddr;
	word_t       wdata;
	logic [3:0]  raddr_a;
	logic [3:0]  raddr_b;

	word_t       pa_prev_q;
	word_t       w_s1;
	word_t       wk_s1;
	word_t       w_d_q;

	logic        accept;
	logic        slot_free;
	logic [4:0]  lane_sh;
	logic [4:0]  pad_sh;
	word_t       acc_new;
	word_t       pad_word;
	logic [63:0] bit_len;
	logic [6:0]  sidx;
	word_t       w_new;
	word_t       wk_new;
	word_t       t1;
	word_t       t2;
	logic [5:0]  p_new;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// byte packing, big-endian within a word
	assign lane_sh  = {~bcnt_q[1:0], 3'b000};
	assign pad_sh   = {bcnt_q[1:0], 3'b000};
	assign acc_new  = (acc_q & ~(32'h0000_00ff << lane_sh))
	                | (word_t'(in_data.data_byte) << lane_sh);
	assign pad_word = (acc_q & ~(32'hffff_ffff >> pad_sh)) | ({PAD_BYTE, 24'h0} >> pad_sh);
	assign bit_len  = {count_q, 3'b000};
	assign p_new    = bcnt_q + 6'(in_data.byte_valid);

	// message schedule, one word ahead of the rounds
	assign sidx    = 7'(cnt_q - SCHED_OFS);
	assign raddr_a = cnt_q[3:0];
	assign raddr_b = 4'(cnt_q[3:0] + TAP7_OFS);
	assign w_new   = (cnt_q < SCHED_FIRST) ? pa_prev_q
	               : pa_prev_q + ssig0(rdata_a_q) + rdata_b_q + ssig1(w_d_q);
	assign wk_new  = w_new + ROUND_K[sidx[5:0]];

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + wk_s1;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		we    = 1'b0;
		waddr = sidx[3:0];
		wdata = w_new;
		unique case (state_q)
			S_IDLE: begin
				we    = accept && in_data.byte_valid && (bcnt_q[1:0] == 2'b11);
				waddr = bcnt_q[5:2];
				wdata = acc_new;
			end
			S_PAD: begin
				we    = 1'b1;
				waddr = pw_q;
				priority if (first_q && (pw_q == bcnt_q[5:2])) begin
					wdata = pad_word;
				end else if (final_q && (pw_q == LEN_HI_IDX)) begin
					wdata = bit_len[63:32];
				end else if (final_q && (pw_q == LEN_LO_IDX)) begin
					wdata = bit_len[31:0];
				end else begin
					wdata = '0;
				end
			end
			S_COMP: begin
				we = (cnt_q >= SCHED_FIRST) && (cnt_q <= SCHED_LAST);
			end
			S_DONE: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pa_prev_q <= rdata_a_q;
		w_d_q     <= w_s1;
		w_s1      <= w_new;
		wk_s1     <= wk_new;
		if (accept && in_data.byte_valid) begin
			acc_q <= acc_new;
		end
		if (state_q == S_COMP) begin
			if (cnt_q == '0) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end else if ((cnt_q >= ROUND_FIRST) && (cnt_q <= ROUND_LAST)) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
		end
		if ((state_q == S_DONE) && slot_free) begin
			out_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pw_q        <= '0;
			first_q     <= 1'b0;
			final_q     <= 1'b0;
			pad_q       <= 1'b0;
			bcnt_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= HASH_IV[i];
			end
		end else begin
			// in S_DONE the hand-over below decides the output valid
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.byte_valid) begin
							bcnt_q <= p_new;
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + 61'd1;
							end
						end
						if (in_data.byte_valid && (bcnt_q == LAST_POS)) begin
							// block full: pad afterwards from byte 0 if the message ends here
							state_q <= S_COMP;
							cnt_q   <= '0;
							pad_q   <= in_data.end_of_message;
							first_q <= 1'b1;
							final_q <= 1'b0;
						end else if (in_data.end_of_message) begin
							state_q <= S_PAD;
							pad_q   <= 1'b1;
							first_q <= 1'b1;
							pw_q    <= p_new[5:2];
							final_q <= (p_new < LEN_POS);
						end
					end
				end
				S_PAD: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == LEN_LO_IDX) begin
						state_q <= S_COMP;
						cnt_q   <= '0;
						first_q <= 1'b0;
					end
				end
				S_COMP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == CNT_LAST) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= h_q[i] + v_q[i];
						end
						priority if (!pad_q) begin
							state_q <= S_IDLE;
						end else if (final_q) begin
							state_q <= S_DONE;
						end else begin
							// length goes into a fresh block
							state_q <= S_PAD;
							pw_q    <= '0;
							final_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= HASH_IV[i];
						end
						bcnt_q  <= '0;
						count_q <= '0;
						pad_q   <= 1'b0;
						first_q <= 1'b0;
						final_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SHS_ASSERT_NOW(a_cnt_range, state_q == S_COMP, cnt_q <= CNT_LAST, "round counter overran")
	`SHS_ASSERT_NOW(a_no_rw_clash, we && (state_q == S_COMP),
		(waddr != raddr_a) && (waddr != raddr_b), "schedule write hits a word being read")
	`SHS_ASSERT_NEXT(a_digest_wait, (state_q == S_DONE) && out_valid_q && out_stall,
		(state_q == S_DONE) && out_valid_q, "digest handed over while slot busy")
	`SHS_ASSERT_NOW(a_idle_no_pad, state_q == S_IDLE, !pad_q, "padding left pending in idle")

endmodule
